FILE: hdl/s16da_pkg.sv
// Shared types and constants for the signed 16-bit to decimal ASCII converter.
package s16da_pkg;

  localparam int unsigned WordW = 16;
  localparam int unsigned CharW = 8;

  // One classified number as it travels from the front end to the back end.
  typedef struct packed {
    logic             neg;
    logic [WordW-1:0] mag;
  } item_t;

endpackage

FILE: hdl/s16da_front.sv
// Front end: accepts input words and splits them into sign and magnitude.
module s16da_front import s16da_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [WordW-1:0] word_value_i,
  output logic             push_valid_o,
  input  logic             push_ready_i,
  output item_t            push_item_o
);

  logic  valid_d, valid_q;
  item_t item_d, item_q;
  logic  take;

  assign in_ready_o = !valid_q || push_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    item_d     = item_q;
    valid_d    = valid_q;
    if (take) begin
      valid_d    = 1'b1;
      item_d.neg = word_value_i[WordW-1];
      // The negation wraps in 16 bits, so the most negative value keeps its
      // pattern and reads back as its own magnitude.
      item_d.mag = word_value_i[WordW-1] ? (~word_value_i + WordW'(1)) : word_value_i;
    end else if (push_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign push_valid_o = valid_q;
  assign push_item_o  = item_q;

endmodule

FILE: hdl/s16da_fifo.sv
// Two-entry queue between the front end and the back end.
module s16da_fifo import s16da_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  item_t push_item_i,
  output logic  pop_valid_o,
  input  logic  pop_ready_i,
  output item_t pop_item_o
);

  item_t      entry_q [2];
  logic       wr_ptr_d, wr_ptr_q;
  logic       rd_ptr_d, rd_ptr_q;
  logic [1:0] count_d, count_q;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ pop;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

FILE: hdl/s16da_back.sv
// Back end: walks the place values of one number and emits its characters.
module s16da_back import s16da_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             pop_valid_i,
  output logic             pop_ready_o,
  input  item_t            pop_item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [CharW-1:0] ascii_char_o,
  output logic             last_char_o
);

  // Step codes: the sign step, then one step per place value.
  localparam logic [2:0] PhSign  = 3'd0;
  localparam logic [2:0] PhFirst = 3'd1;
  localparam logic [2:0] PhLast  = 3'd5;

  localparam logic [CharW-1:0] AsciiMinus = CharW'(45);
  localparam logic [CharW-1:0] AsciiZero  = CharW'(48);

  function automatic logic [13:0] place_of(input logic [2:0] ph);
    logic [13:0] p;
    case (ph)
      3'd1:    p = 14'd10000;
      3'd2:    p = 14'd1000;
      3'd3:    p = 14'd100;
      3'd4:    p = 14'd10;
      3'd5:    p = 14'd1;
      default: p = 14'd0;
    endcase
    return p;
  endfunction

  logic             busy_d, busy_q;
  logic [2:0]       phase_d, phase_q;
  logic             started_d, started_q;
  logic [WordW-1:0] rem_d, rem_q;
  logic             out_valid_d, out_valid_q;
  logic [CharW-1:0] char_d, char_q;
  logic             last_d, last_q;

  logic [2:0]       cur_phase;
  logic [WordW-1:0] cur_rem;
  logic             cur_started;
  logic [13:0]      place;
  logic [3:0]       digit;
  logic [WordW-1:0] sub;
  logic             is_sign, is_last, emit, adv;

  // The working number comes from the step registers while busy, otherwise
  // straight from the queue head so a new number starts without a bubble.
  assign cur_phase   = busy_q ? phase_q : (pop_item_i.neg ? PhSign : PhFirst);
  assign cur_rem     = busy_q ? rem_q : pop_item_i.mag;
  assign cur_started = busy_q && started_q;
  assign place       = place_of(cur_phase);
  assign is_sign     = (cur_phase == PhSign);
  assign is_last     = (cur_phase == PhLast);

  assign adv         = (busy_q || pop_valid_i) && (!out_valid_q || out_ready_i);
  assign pop_ready_o = adv && !busy_q;

  // The digit is the largest multiple of the place value not above the rest.
  // A chosen multiple never exceeds the rest, so it fits in the word width.
  always_comb begin
    logic [16:0] kp;
    digit = 4'd0;
    sub   = '0;
    for (int k = 1; k < 10; k++) begin
      kp = 17'(k) * {3'b000, place};
      if ({1'b0, cur_rem} >= kp) begin
        digit = 4'(k);
        sub   = kp[WordW-1:0];
      end
    end
  end

  assign emit = is_sign || is_last || cur_started || (digit != 4'd0);

  always_comb begin
    busy_d      = busy_q;
    phase_d     = phase_q;
    started_d   = started_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q;
    char_d      = char_q;
    last_d      = last_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (adv) begin
      if (is_sign) begin
        busy_d    = 1'b1;
        phase_d   = PhFirst;
        rem_d     = cur_rem;
        started_d = 1'b0;
      end else if (is_last) begin
        busy_d    = 1'b0;
        started_d = 1'b0;
      end else begin
        busy_d    = 1'b1;
        phase_d   = cur_phase + 3'd1;
        rem_d     = cur_rem - sub;
        started_d = cur_started || (digit != 4'd0);
      end
      if (emit) begin
        out_valid_d = 1'b1;
        char_d      = is_sign ? AsciiMinus : (AsciiZero + {4'b0000, digit});
        last_d      = is_last;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      phase_q     <= PhSign;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      phase_q     <= phase_d;
      started_q   <= started_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign ascii_char_o = char_q;
  assign last_char_o  = last_q;

  // The sign step never leaves the sequencer parked; a busy number is always
  // on one of the place-value steps.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (phase_q >= PhFirst && phase_q <= PhLast))
    else $error("back end busy on an invalid step");

  // A pending character that is not the last one means its number is unfinished.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !last_q) |-> busy_q)
    else $error("non-final character pending with no number in progress");

  // After a place-value step the rest is below that place value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && phase_q > PhFirst) |->
      ({1'b0, rem_q} < 17'(place_of(phase_q - 3'd1))))
    else $error("remainder not reduced below the previous place value");

endmodule

FILE: hdl/signed16_to_decimal_ascii.sv
// Top level of the signed 16-bit to decimal ASCII converter.
//
//   Channel  Direction  Handshake                  Fields
//   in       input      in_valid_i / in_ready_o    word_value_i
//   out      output     out_valid_o / out_ready_i  ascii_char_o, last_char_o
//
// The back end spends one step on the sign of a negative number and one
// step per place value (five), and a step waits while the output side stalls;
// the single shared digit step in the back end takes these steps in turn.
// The front end registers and classifies words and a two-entry queue lets it
// keep accepting while the back end is stalled by the output side.
// Reset is asynchronous and active low and clears all control state.
module signed16_to_decimal_ascii import s16da_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [WordW-1:0] word_value_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [CharW-1:0] ascii_char_o,
  output logic             last_char_o
);

  logic  push_valid, push_ready;
  item_t push_item;
  logic  pop_valid, pop_ready;
  item_t pop_item;

  s16da_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .word_value_i (word_value_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  s16da_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  s16da_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_item_i   (pop_item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .ascii_char_o (ascii_char_o),
    .last_char_o  (last_char_o)
  );

endmodule
